### hw/rtl/assert_macros.svh
// Assertion macros shared by the sobel gradient energy RTL.
// No dependencies; define SYNTH to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every rising clock edge outside reset.
`define SGE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sge assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define SGE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sge assertion failed");
`else
`define SGE_ASSERT(lbl, clk, rst_n, prop)
`define SGE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/sge_pkg.sv
// Shared types and constants of the sobel gradient energy block.
// No dependencies; imported by every module of the block.
`default_nettype none

package sge_pkg;

  localparam int SAMPLE_BITS       = 8;
  localparam int CHANNELS          = 3;
  localparam int MAX_WIDTH_DEFAULT = 1024;
  localparam int HEIGHT_LIMIT      = 4096;

  localparam int WIDTH_REG_BITS  = 11;
  localparam int HEIGHT_REG_BITS = 13;
  localparam int CFG_DATA_BITS   = 13;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int ROW_BITS        = 13;
  localparam int OUT_COL_BITS    = 10;
  localparam int OUT_ROW_BITS    = 12;
  localparam int SUM_BITS        = SAMPLE_BITS + 2;
  localparam int ENERGY_BITS     = SAMPLE_BITS + 3;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [WIDTH_REG_BITS-1:0]  IMAGE_WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_BITS-1:0] IMAGE_HEIGHT_RESET = 13'd480;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [CHANNELS-1:0] pixel_t;
  // Rows 0..2 top to bottom, columns 0..2 left to right.
  typedef pixel_t [2:0][2:0] window_t;
  typedef logic [ENERGY_BITS-1:0] energy_t;
  typedef energy_t [CHANNELS-1:0] energies_t;

  typedef struct packed {
    sample_t red;
    sample_t green;
    sample_t blue;
    logic    flush;
  } in_item_t;

  typedef struct packed {
    energy_t                 energy_red;
    energy_t                 energy_green;
    energy_t                 energy_blue;
    logic [OUT_COL_BITS-1:0] column;
    logic [OUT_ROW_BITS-1:0] row;
    logic                    frame_end;
  } out_item_t;

  // Position and neighbor mask of the pixel whose result an item completes.
  typedef struct packed {
    logic                    emit;
    logic                    last;
    logic                    nb_top;
    logic                    nb_bot;
    logic                    nb_lft;
    logic                    nb_rgt;
    logic [OUT_COL_BITS-1:0] column;
    logic [OUT_ROW_BITS-1:0] row;
  } pos_tag_t;

endpackage

`default_nettype wire

### hw/rtl/sge_ctrl.sv
// Frame geometry registers and raster position tracking.
// Depends on sge_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sge_ctrl #(
  parameter int  MAX_WIDTH = sge_pkg::MAX_WIDTH_DEFAULT,
  localparam int COL_W     = $clog2(MAX_WIDTH)
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_valid,
  input  wire logic [sge_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [sge_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                               accept,
  input  wire logic                               flush,
  output logic      [COL_W-1:0]                   rd_col,
  output logic                                    zero_px,
  output sge_pkg::pos_tag_t                       tag
);
  import sge_pkg::*;

  localparam int PW = (COL_W + 1 > WIDTH_REG_BITS) ? COL_W + 1 : WIDTH_REG_BITS;
  localparam logic [PW-1:0]              W_MAX = PW'(MAX_WIDTH);
  localparam logic [HEIGHT_REG_BITS-1:0] H_MAX = HEIGHT_REG_BITS'(HEIGHT_LIMIT);

  logic [WIDTH_REG_BITS-1:0]  width_r, width_nxt;
  logic [HEIGHT_REG_BITS-1:0] height_r, height_nxt;
  logic [COL_W-1:0]           col_r, col_nxt;
  logic [ROW_BITS-1:0]        row_r, row_nxt;

  logic [PW-1:0]              w_ext, w_eff, col_pe, col_inc, qc;
  logic [HEIGHT_REG_BITS-1:0] h_eff;
  logic [COL_W-1:0]           col;
  logic [ROW_BITS-1:0]        qr, row_step;
  logic                       emit_raw, emit, last;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_nxt  = cfg_data[WIDTH_REG_BITS-1:0];
        CFG_IMAGE_HEIGHT: height_nxt = cfg_data[HEIGHT_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_ext = PW'(width_r);
    if (w_ext == '0) begin
      w_eff = PW'(1);
    end else if (w_ext > W_MAX) begin
      w_eff = W_MAX;
    end else begin
      w_eff = w_ext;
    end
    if (height_r == '0) begin
      h_eff = HEIGHT_REG_BITS'(1);
    end else if (height_r > H_MAX) begin
      h_eff = H_MAX;
    end else begin
      h_eff = height_r;
    end

    // a column left over from a wider frame restarts the row
    col    = (PW'(col_r) >= w_eff) ? '0 : col_r;
    col_pe = PW'(col);

    // the pixel whose lower-right neighbor is the current item
    if (col != '0) begin
      emit_raw = (row_r != '0);
      qc       = col_pe - PW'(1);
      qr       = row_r - ROW_BITS'(1);
    end else begin
      emit_raw = (row_r >= ROW_BITS'(2));
      qc       = w_eff - PW'(1);
      qr       = row_r - ROW_BITS'(2);
    end
    emit = emit_raw && (qr < h_eff);
    last = emit && (qr == h_eff - HEIGHT_REG_BITS'(1)) && (qc == w_eff - PW'(1));

    tag.emit   = emit;
    tag.last   = last;
    tag.nb_top = (qr != '0);
    tag.nb_bot = ({1'b0, qr} + 14'd1) < {1'b0, h_eff};
    tag.nb_lft = (qc != '0);
    tag.nb_rgt = (qc + PW'(1)) < w_eff;
    tag.column = qc[OUT_COL_BITS-1:0];
    tag.row    = qr[OUT_ROW_BITS-1:0];

    zero_px = flush || (row_r >= h_eff);
    rd_col  = col;

    col_inc = col_pe + PW'(1);
    if (col_inc >= w_eff) begin
      col_nxt  = '0;
      row_step = row_r + ROW_BITS'(1);
    end else begin
      col_nxt  = col_inc[COL_W-1:0];
      row_step = row_r;
    end
    row_nxt = row_step;
    if (last) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if ({1'b0, row_step} > ({1'b0, h_eff} + 14'd1)) begin
      // ran past the drain rows: start over without a frame end
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= IMAGE_WIDTH_RESET;
      height_r <= IMAGE_HEIGHT_RESET;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  `SGE_ASSERT_NEXT(a_frame_restart, clk, rst_n, accept && tag.last, col_r == '0 && row_r == '0)

endmodule

`default_nettype wire

### hw/rtl/sge_line_store.sv
// Two line memories holding the rows one and two above the current pixel.
// Depends on sge_pkg.
`default_nettype none

module sge_line_store #(
  parameter int  MAX_WIDTH = sge_pkg::MAX_WIDTH_DEFAULT,
  localparam int COL_W     = $clog2(MAX_WIDTH)
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [COL_W-1:0] rd_addr,
  input  wire logic             wr_en,
  input  wire logic [COL_W-1:0] wr_addr,
  input  wire sge_pkg::pixel_t  wr_above,
  input  wire sge_pkg::pixel_t  wr_two,
  output sge_pkg::pixel_t       rd_above,
  output sge_pkg::pixel_t       rd_two
);
  import sge_pkg::*;

  pixel_t above_mem [MAX_WIDTH];
  pixel_t two_mem   [MAX_WIDTH];
  pixel_t rd_above_r, rd_two_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      above_mem[wr_addr] <= wr_above;
      two_mem[wr_addr]   <= wr_two;
    end
    if (rd_en) begin
      // same column written this cycle (one-pixel rows): take the new data
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_above_r <= wr_above;
        rd_two_r   <= wr_two;
      end else begin
        rd_above_r <= above_mem[rd_addr];
        rd_two_r   <= two_mem[rd_addr];
      end
    end
  end

  assign rd_above = rd_above_r;
  assign rd_two   = rd_two_r;

endmodule

`default_nettype wire

### hw/rtl/sge_window.sv
// 3x3 neighborhood register, shifted left one column per pixel.
// Depends on sge_pkg.
`default_nettype none

module sge_window (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            shift,
  input  wire sge_pkg::pixel_t col_top,
  input  wire sge_pkg::pixel_t col_mid,
  input  wire sge_pkg::pixel_t col_bot,
  output sge_pkg::window_t     win
);
  import sge_pkg::*;

  window_t win_r, win_nxt;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = col_top;
    win_nxt[1][2] = col_mid;
    win_nxt[2][2] = col_bot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (shift) begin
      win_r <= win_nxt;
    end
  end

  assign win = win_r;

endmodule

`default_nettype wire

### hw/rtl/sge_energy.sv
// Per-channel |Gx| + |Gy| over the window, outside neighbors forced to zero.
// Depends on sge_pkg.
`default_nettype none

module sge_energy (
  input  wire sge_pkg::window_t  win,
  input  wire sge_pkg::pos_tag_t tag,
  output sge_pkg::energies_t     energy
);
  import sge_pkg::*;

  always_comb begin
    logic [SUM_BITS-1:0] tl, tm, tr, ml, mr, bl, bm, br;
    logic [SUM_BITS-1:0] sa, sb, gx, gy;
    for (int k = 0; k < CHANNELS; k++) begin
      tl = (tag.nb_top && tag.nb_lft) ? SUM_BITS'(win[0][0][k]) : '0;
      tm = tag.nb_top                 ? SUM_BITS'(win[0][1][k]) : '0;
      tr = (tag.nb_top && tag.nb_rgt) ? SUM_BITS'(win[0][2][k]) : '0;
      ml = tag.nb_lft                 ? SUM_BITS'(win[1][0][k]) : '0;
      mr = tag.nb_rgt                 ? SUM_BITS'(win[1][2][k]) : '0;
      bl = (tag.nb_bot && tag.nb_lft) ? SUM_BITS'(win[2][0][k]) : '0;
      bm = tag.nb_bot                 ? SUM_BITS'(win[2][1][k]) : '0;
      br = (tag.nb_bot && tag.nb_rgt) ? SUM_BITS'(win[2][2][k]) : '0;

      sa = tl + (tm << 1) + tr;
      sb = bl + (bm << 1) + br;
      gy = (sa > sb) ? sa - sb : sb - sa;

      sa = tl + (ml << 1) + bl;
      sb = tr + (mr << 1) + br;
      gx = (sa > sb) ? sa - sb : sb - sa;

      energy[k] = ENERGY_BITS'(gx) + ENERGY_BITS'(gy);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sobel_gradient_energy.sv
// Streaming 3x3 Sobel edge energy (L1 magnitude) per RGB channel.
// Depends on sge_pkg, sge_ctrl, sge_line_store, sge_window, sge_energy, assert_macros.svh.
//
// Usage:
//   in_*   : one RGB pixel per request in raster order; flush = 1 sends a
//            zero pixel. After the last pixel of a frame, send width + 1
//            more items (flush or not) to drain the trailing results.
//   out_*  : one result per pixel with its column, row and frame_end on
//            the last pixel of the frame.
//   cfg_*  : index 0 image_width, index 1 image_height. Always ready;
//            write only while the block is idle.
// A pixel's result is finished by the item at its lower-right neighbor;
// it shows on out_valid once that item has passed the accepting edge (line
// store read), then the window shift and then the result register.
// Throughput is one item per clock while in_stall stays low, set by one
// read and one write per cycle on each line memory.
// Reset sets 640 x 480, empties the pipeline and puts the next item at
// pixel (0,0). The line memories are not cleared; no clearing pass runs.
// While out_stall holds a result, the two inner stages keep taking items,
// then in_stall rises until the result register drains.
`default_nettype none
`include "assert_macros.svh"

module sobel_gradient_energy #(
  parameter int MAX_WIDTH = sge_pkg::MAX_WIDTH_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire sge_pkg::in_item_t                  in_payload,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output sge_pkg::out_item_t                      out_payload,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [sge_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [sge_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import sge_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic             accept, move_ab, b_retire, b_free, c_free, out_fire;
  logic [COL_W-1:0] rd_col;
  logic             zero_px;
  pos_tag_t         tag;
  pixel_t           in_px, rd_above, rd_two;
  window_t          win;
  energies_t        energy;

  logic             a_v_r, a_v_nxt;
  pixel_t           a_px_r;
  logic [COL_W-1:0] a_col_r;
  pos_tag_t         a_tag_r;
  logic             b_v_r, b_v_nxt;
  pos_tag_t         b_tag_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_payload_r;

  assign cfg_ready = 1'b1;

  // a non-emitting item leaves the window stage without the result register
  assign out_fire = out_valid_r && !out_stall;
  assign c_free   = !out_valid_r || !out_stall;
  assign b_retire = b_v_r && (!b_tag_r.emit || c_free);
  assign b_free   = !b_v_r || b_retire;
  assign move_ab  = a_v_r && b_free;
  assign in_stall = a_v_r && !b_free;
  assign accept   = in_valid && !in_stall;

  assign in_px[0] = in_payload.red;
  assign in_px[1] = in_payload.green;
  assign in_px[2] = in_payload.blue;

  sge_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .flush     (in_payload.flush),
    .rd_col    (rd_col),
    .zero_px   (zero_px),
    .tag       (tag)
  );

  sge_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_lines (
    .clk      (clk),
    .rd_en    (accept),
    .rd_addr  (rd_col),
    .wr_en    (move_ab),
    .wr_addr  (a_col_r),
    .wr_above (a_px_r),
    .wr_two   (rd_above),
    .rd_above (rd_above),
    .rd_two   (rd_two)
  );

  sge_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .shift   (move_ab),
    .col_top (rd_two),
    .col_mid (rd_above),
    .col_bot (a_px_r),
    .win     (win)
  );

  sge_energy u_energy (
    .win    (win),
    .tag    (b_tag_r),
    .energy (energy)
  );

  always_comb begin
    a_v_nxt = a_v_r;
    if (accept) begin
      a_v_nxt = 1'b1;
    end else if (move_ab) begin
      a_v_nxt = 1'b0;
    end
    b_v_nxt = b_v_r;
    if (move_ab) begin
      b_v_nxt = 1'b1;
    end else if (b_retire) begin
      b_v_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (b_retire && b_tag_r.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_v_r       <= a_v_nxt;
      b_v_r       <= b_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_px_r  <= zero_px ? '0 : in_px;
      a_col_r <= rd_col;
      a_tag_r <= tag;
    end
    if (move_ab) begin
      b_tag_r <= a_tag_r;
    end
    if (b_retire && b_tag_r.emit) begin
      out_payload_r.energy_red   <= energy[0];
      out_payload_r.energy_green <= energy[1];
      out_payload_r.energy_blue  <= energy[2];
      out_payload_r.column       <= b_tag_r.column;
      out_payload_r.row          <= b_tag_r.row;
      out_payload_r.frame_end    <= b_tag_r.last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

  `SGE_ASSERT(a_stall_needs_item, clk, rst_n, !in_stall || a_v_r)
  `SGE_ASSERT(a_result_source, clk, rst_n, !$rose(out_valid_r) || $past(b_retire && b_tag_r.emit))
  `SGE_ASSERT_NEXT(a_window_held, clk, rst_n, b_v_r && b_tag_r.emit && out_valid_r && out_stall, b_v_r && $stable(b_tag_r))

endmodule

`default_nettype wire
